>>> src/ift_pkg.sv
// ----------------------------------------------------------------------------
// ift_pkg
// Shared types and constants of the IP fragment tracker: field widths,
// report status codes, register index and controller/datapath handshake.
// ----------------------------------------------------------------------------
package ift_pkg;

    localparam int ID_W     = 16;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int OFFSET_W = 13;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [STATUS_W-1:0] ST_REPORTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

    localparam logic REG_SOURCE_ADDR = 1'b0;

    typedef struct packed {
        logic capture;
        logic update;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic used_le1;
    } t_dp_stat;

endpackage

>>> src/ip_fragment_tracker.sv
// ----------------------------------------------------------------------------
// ip_fragment_tracker
// A packet header is captured, then matched and appended over all entries
// in one parallel step; busy is high during that step. An end_of_trace
// item is captured, then the report walks the table one entry per cycle
// (one step for an empty table), and its results come on consecutive cycles,
// one cycle each, marked by o_result_valid. The receiver cannot stall them.
// source_addr sits at APB byte address 0.
// ----------------------------------------------------------------------------
module ip_fragment_tracker
    import ift_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_end_of_trace,
    input  logic                i_more_fragments,
    input  logic [OFFSET_W-1:0] i_frag_offset,
    input  logic [ID_W-1:0]     i_datagram_id,
    input  logic [ADDR_W-1:0]   i_src_addr,
    output logic                o_result_valid,
    output logic [ID_W-1:0]     o_report_id,
    output logic [COUNT_W-1:0]  o_fragment_count,
    output logic [OFFSET_W-1:0] o_last_offset,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_table_overflowed,
    output logic                o_last_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [ADDR_W-1:0] r_source_addr;
    logic              w_reg_idx;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_addr <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_SOURCE_ADDR: r_source_addr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_SOURCE_ADDR: prdata = r_source_addr;
            default:         prdata = '0;
        endcase
    end

    ift_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_end_of_trace (i_end_of_trace),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_busy         (busy)
    );

    ift_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_source_addr      (r_source_addr),
        .i_more_fragments   (i_more_fragments),
        .i_frag_offset      (i_frag_offset),
        .i_datagram_id      (i_datagram_id),
        .i_src_addr         (i_src_addr),
        .o_result_valid     (o_result_valid),
        .o_report_id        (o_report_id),
        .o_fragment_count   (o_fragment_count),
        .o_last_offset      (o_last_offset),
        .o_status           (o_status),
        .o_table_overflowed (o_table_overflowed),
        .o_last_result      (o_last_result)
    );

endmodule

>>> src/ift_ctrl.sv
// ----------------------------------------------------------------------------
// ift_ctrl
// Controller: sequences packet capture, table update and the report walk.
// ----------------------------------------------------------------------------
module ift_ctrl
    import ift_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_end_of_trace,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PKT  = 3'b010,
        S_RPT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_end_of_trace ? S_RPT : S_PKT;
                end
            end
            S_PKT: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            S_RPT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.used_le1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> src/ift_table.sv
// ----------------------------------------------------------------------------
// ift_table
// Datapath: entry cells with parallel match, append at the fill count,
// shift-out report walk and the registered result stage.
// ----------------------------------------------------------------------------
module ift_table
    import ift_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [ADDR_W-1:0]   i_source_addr,
    input  logic                i_more_fragments,
    input  logic [OFFSET_W-1:0] i_frag_offset,
    input  logic [ID_W-1:0]     i_datagram_id,
    input  logic [ADDR_W-1:0]   i_src_addr,
    output logic                o_result_valid,
    output logic [ID_W-1:0]     o_report_id,
    output logic [COUNT_W-1:0]  o_fragment_count,
    output logic [OFFSET_W-1:0] o_last_offset,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_table_overflowed,
    output logic                o_last_result
);

    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    logic                r_mf;
    logic [OFFSET_W-1:0] r_off;
    logic [ID_W-1:0]     r_pid;
    logic [ADDR_W-1:0]   r_psrc;

    logic [ID_W-1:0]     r_id     [TABLE_DEPTH];
    logic [ADDR_W-1:0]   r_src    [TABLE_DEPTH];
    logic [COUNT_W-1:0]  r_count  [TABLE_DEPTH];
    logic [OFFSET_W-1:0] r_offset [TABLE_DEPTH];
    logic                r_closed [TABLE_DEPTH];

    logic [ID_W-1:0]     w_sh_id     [TABLE_DEPTH];
    logic [ADDR_W-1:0]   w_sh_src    [TABLE_DEPTH];
    logic [COUNT_W-1:0]  w_sh_count  [TABLE_DEPTH];
    logic [OFFSET_W-1:0] w_sh_offset [TABLE_DEPTH];
    logic                w_sh_closed [TABLE_DEPTH];

    logic [USED_W-1:0]   r_used;
    logic                r_ovf;
    logic                w_open;
    logic                w_full;
    logic                w_empty;
    logic                w_found;

    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_id;
    logic [COUNT_W-1:0]  r_out_count;
    logic [OFFSET_W-1:0] r_out_offset;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_ovf;
    logic                r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mf   <= i_more_fragments;
            r_off  <= i_frag_offset;
            r_pid  <= i_datagram_id;
            r_psrc <= i_src_addr;
        end
    end

    assign w_open  = r_mf && (r_off == '0) && (r_psrc == i_source_addr);
    assign w_full  = (r_used == USED_W'(TABLE_DEPTH));
    assign w_empty = (r_used == '0);
    assign o_stat.used_le1 = (r_used <= USED_W'(1));

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic w_valid;
        logic w_hit;
        logic w_new;

        if (k == TABLE_DEPTH - 1) begin : g_tail
            assign w_sh_id[k]     = r_id[k];
            assign w_sh_src[k]    = r_src[k];
            assign w_sh_count[k]  = r_count[k];
            assign w_sh_offset[k] = r_offset[k];
            assign w_sh_closed[k] = r_closed[k];
        end else begin : g_body
            assign w_sh_id[k]     = r_id[k+1];
            assign w_sh_src[k]    = r_src[k+1];
            assign w_sh_count[k]  = r_count[k+1];
            assign w_sh_offset[k] = r_offset[k+1];
            assign w_sh_closed[k] = r_closed[k+1];
        end

        assign w_valid = (USED_W'(k) < r_used);
        assign w_hit   = w_valid && !r_closed[k] && (r_id[k] == r_pid)
                         && (r_src[k] == r_psrc);
        assign w_new   = w_open && !w_full && (USED_W'(k) == r_used);

        always_ff @(posedge i_clk) begin
            if (i_cmd.emit) begin
                r_id[k]     <= w_sh_id[k];
                r_src[k]    <= w_sh_src[k];
                r_count[k]  <= w_sh_count[k];
                r_offset[k] <= w_sh_offset[k];
                r_closed[k] <= w_sh_closed[k];
            end else if (i_cmd.update) begin
                if (w_hit) begin
                    if (r_count[k] != '1) begin
                        r_count[k] <= r_count[k] + COUNT_W'(1);
                    end
                    r_offset[k] <= r_off;
                    if (!r_mf) begin
                        r_closed[k] <= 1'b1;
                    end
                end else if (w_new) begin
                    r_id[k]     <= r_pid;
                    r_src[k]    <= r_psrc;
                    r_count[k]  <= COUNT_W'(1);
                    r_offset[k] <= '0;
                    r_closed[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.update) begin
            if (w_open && w_full) begin
                r_ovf <= 1'b1;
            end else if (w_open) begin
                r_used <= r_used + USED_W'(1);
            end
        end else if (i_cmd.emit) begin
            if (!w_empty) begin
                r_used <= r_used - USED_W'(1);
            end
            if (o_stat.used_le1) begin
                r_ovf <= 1'b0;
            end
        end
    end

    assign w_found = (r_count[0] != COUNT_W'(1)) && (r_offset[0] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ovf <= r_ovf;
            if (w_empty) begin
                r_out_id     <= '0;
                r_out_count  <= '0;
                r_out_offset <= '0;
                r_out_status <= ST_EMPTY;
                r_out_last   <= 1'b1;
            end else begin
                r_out_id     <= r_id[0];
                r_out_count  <= w_found ? r_count[0] : '0;
                r_out_offset <= w_found ? r_offset[0] : '0;
                r_out_status <= w_found ? ST_REPORTED : ST_NOT_FOUND;
                r_out_last   <= (r_used == USED_W'(1));
            end
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_report_id        = r_out_id;
    assign o_fragment_count   = r_out_count;
    assign o_last_offset      = r_out_offset;
    assign o_status           = r_out_status;
    assign o_table_overflowed = r_out_ovf;
    assign o_last_result      = r_out_last;

endmodule
